FILE: design/serial_frame_receive_checker_assert.svh
// ----------------------------------------------------------------------------
// Serial frame receive checker assertion macros
// Shared property wrappers, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVE_CHECKER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVE_CHECKER_ASSERT_SVH

// same-cycle implication
`define SFRC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfrc assertion failed");

// next-cycle implication
`define SFRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfrc assertion failed");

`endif

FILE: design/sfrc_pkg.sv
// ----------------------------------------------------------------------------
// sfrc_pkg
// Types and constants of the serial frame receive checker.
// ----------------------------------------------------------------------------
package sfrc_pkg;

    localparam int unsigned CountW    = 9;
    localparam logic [CountW-1:0] MaxFrame = 9'd256;
    localparam logic [CountW-1:0] MinFrame = 9'd3;

    localparam logic [7:0]  BroadcastId = 8'hFF;
    localparam logic [15:0] CrcInit     = 16'hFFFF;
    localparam logic [15:0] CrcPoly     = 16'hA001;
    localparam logic [15:0] SilenceMax  = 16'hFFFF;

    localparam logic [7:0]  StationReset = 8'd1;
    localparam logic [15:0] GapReset     = 16'd750;

    // register index, taken from paddr[2]
    localparam logic RegStationAddr = 1'b0;
    localparam logic RegGapTicks    = 1'b1;

    localparam logic ModeByte = 1'b0;
    localparam logic ModeTick = 1'b1;

    typedef enum logic [1:0] {
        StatusOk           = 2'd0,
        StatusOtherStation = 2'd1,
        StatusCrcError     = 2'd2,
        StatusBadLength    = 2'd3
    } t_status;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic              broadcast;
        logic [CountW-1:0] frame_length;
        logic [7:0]        function_code;
    } t_out_item;

endpackage

FILE: design/sfrc_crc16.sv
// ----------------------------------------------------------------------------
// sfrc_crc16
// One byte step of the reflected CRC-16 (polynomial 0xA001).
// ----------------------------------------------------------------------------
module sfrc_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[0]) begin
                v_crc = (v_crc >> 1) ^ sfrc_pkg::CrcPoly;
            end else begin
                v_crc = v_crc >> 1;
            end
        end
        o_crc = v_crc;
    end

endmodule

FILE: design/sfrc_frame_tracker.sv
// ----------------------------------------------------------------------------
// sfrc_frame_tracker
// Frame state (CRC, count, head and tail bytes, silence) and end-of-frame verdict.
// ----------------------------------------------------------------------------
module sfrc_frame_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  sfrc_pkg::t_in_item  i_item,
    input  logic [7:0]          i_station_address,
    input  logic [15:0]         i_gap_ticks,
    output logic                o_res_valid,
    output sfrc_pkg::t_out_item o_res
);

    logic [15:0]                 r_crc,      n_crc;
    logic [sfrc_pkg::CountW-1:0] r_count,    n_count;
    logic [15:0]                 r_tail,     n_tail;
    logic [7:0]                  r_station,  n_station;
    logic [7:0]                  r_function, n_function;
    logic [15:0]                 r_silence,  n_silence;
    logic                        r_overflow, n_overflow;
    logic [15:0]                 w_crc_next;
    logic [15:0]                 w_silence_inc;
    logic [15:0]                 w_expected;
    logic                        w_bcast;

    sfrc_crc16 u_crc (
        .i_crc  (r_crc),
        .i_byte (r_tail[15:8]),
        .o_crc  (w_crc_next)
    );

    assign w_silence_inc = (r_silence == sfrc_pkg::SilenceMax) ? r_silence : r_silence + 16'd1;
    assign w_expected    = {r_tail[7:0], r_tail[15:8]};
    assign w_bcast       = (r_station == sfrc_pkg::BroadcastId);

    always_comb begin
        n_crc       = r_crc;
        n_count     = r_count;
        n_tail      = r_tail;
        n_station   = r_station;
        n_function  = r_function;
        n_silence   = r_silence;
        n_overflow  = r_overflow;
        o_res_valid = 1'b0;

        o_res.broadcast     = w_bcast;
        o_res.frame_length  = r_count;
        o_res.function_code = r_function;
        if (r_overflow || r_count < sfrc_pkg::MinFrame) begin
            o_res.status = sfrc_pkg::StatusBadLength;
        end else if (!w_bcast && r_station != i_station_address) begin
            o_res.status = sfrc_pkg::StatusOtherStation;
        end else if (r_crc != w_expected) begin
            o_res.status = sfrc_pkg::StatusCrcError;
        end else begin
            o_res.status = sfrc_pkg::StatusOk;
        end

        if (i_step) begin
            if (i_item.mode == sfrc_pkg::ModeByte) begin
                n_silence = '0;
                if (r_count >= sfrc_pkg::MaxFrame) begin
                    // drop bytes past the limit
                    n_overflow = 1'b1;
                end else begin
                    if (r_count == 9'd0) begin
                        n_station = i_item.rx_byte;
                    end
                    if (r_count == 9'd1) begin
                        n_function = i_item.rx_byte;
                    end
                    // CRC lags two bytes so the trailing CRC stays out of it
                    if (r_count >= 9'd2) begin
                        n_crc = w_crc_next;
                    end
                    n_tail  = {r_tail[7:0], i_item.rx_byte};
                    n_count = r_count + 9'd1;
                end
            end else if (r_count != 9'd0 || r_overflow) begin
                if (w_silence_inc < i_gap_ticks) begin
                    n_silence = w_silence_inc;
                end else begin
                    o_res_valid = 1'b1;
                    n_crc       = sfrc_pkg::CrcInit;
                    n_count     = '0;
                    n_tail      = '0;
                    n_station   = '0;
                    n_function  = '0;
                    n_silence   = '0;
                    n_overflow  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc      <= sfrc_pkg::CrcInit;
            r_count    <= '0;
            r_tail     <= '0;
            r_station  <= '0;
            r_function <= '0;
            r_silence  <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_crc      <= n_crc;
            r_count    <= n_count;
            r_tail     <= n_tail;
            r_station  <= n_station;
            r_function <= n_function;
            r_silence  <= n_silence;
            r_overflow <= n_overflow;
        end
    end

`include "serial_frame_receive_checker_assert.svh"

    `SFRC_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= sfrc_pkg::MaxFrame)
    `SFRC_ASSERT_IMPL(a_overflow_full, r_overflow, r_count == sfrc_pkg::MaxFrame)
    `SFRC_ASSERT_NEXT(a_clear_after_verdict, o_res_valid, r_count == 9'd0 && r_crc == sfrc_pkg::CrcInit && !r_overflow)

endmodule

FILE: design/serial_frame_receive_checker.sv
// ----------------------------------------------------------------------------
// serial_frame_receive_checker
// Receive-side frame checker for RTU-style serial frames with CRC-16.
// ----------------------------------------------------------------------------
// Each transaction on the input is either a received byte or one microsecond
// tick. Bytes build up a frame; once gap_ticks silent ticks follow, one
// verdict transaction comes out (length, then station, then CRC check).
// One item is taken per clock unless the input stalls: it is captured in an input
// register, the frame state is updated by a single combinational step from that
// register, and a verdict lands in the output register. Throughput is one item per
// cycle, limited only by stall on the output while a verdict waits there.
module serial_frame_receive_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sfrc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sfrc_pkg::t_out_item o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [7:0]          r_station;
    logic [15:0]         r_gap;
    logic                r_in_valid;
    sfrc_pkg::t_in_item  r_in_item;
    logic                r_out_valid;
    sfrc_pkg::t_out_item r_out_item;
    logic                w_step;
    logic                w_in_accept;
    logic                w_res_valid;
    sfrc_pkg::t_out_item w_res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sfrc_pkg::RegGapTicks) ? {16'h0000, r_gap}
                                                         : {24'h000000, r_station};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station <= sfrc_pkg::StationReset;
            r_gap     <= sfrc_pkg::GapReset;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == sfrc_pkg::RegStationAddr) begin
                r_station <= pwdata[7:0];
            end else begin
                r_gap <= pwdata[15:0];
            end
        end
    end

    assign w_step      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_step;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
            r_in_item  <= i_in_data;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    sfrc_frame_tracker u_tracker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (w_step),
        .i_item            (r_in_item),
        .i_station_address (r_station),
        .i_gap_ticks       (r_gap),
        .o_res_valid       (w_res_valid),
        .o_res             (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_res_valid) begin
            r_out_valid <= 1'b1;
            r_out_item  <= w_res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

`include "serial_frame_receive_checker_assert.svh"

    `SFRC_ASSERT_IMPL(a_stall_only_when_full, o_in_stall, r_in_valid && r_out_valid)
    `SFRC_ASSERT_NEXT(a_hold_unconsumed, r_in_valid && !w_step, r_in_valid && $stable(r_in_item))
    `SFRC_ASSERT_IMPL(a_result_from_step, $rose(r_out_valid), $past(w_step && w_res_valid))

endmodule
